>>> sv/pdc_pkg.sv
package pdc_pkg;

  // Sync word and the 8-bit sum of its four bytes
  localparam logic [31:0] SYNC_PATTERN = 32'hEF02_AAAA;
  localparam logic [7:0]  SYNC_SUM     = 8'h45;

  // Result queue depth between the parser and the output stage
  localparam int QUEUE_DEPTH = 2;

  // Header byte positions, low byte first for multi-byte fields
  localparam logic [3:0] HPOS_TGT_LO  = 4'd0;
  localparam logic [3:0] HPOS_TGT_HI  = 4'd1;
  localparam logic [3:0] HPOS_SRC_LO  = 4'd2;
  localparam logic [3:0] HPOS_SRC_HI  = 4'd3;
  localparam logic [3:0] HPOS_SEQ_LO  = 4'd4;
  localparam logic [3:0] HPOS_SEQ_HI  = 4'd5;
  localparam logic [3:0] HPOS_FUNC    = 4'd6;
  localparam logic [3:0] HPOS_LEN_LO  = 4'd7;
  localparam logic [3:0] HPOS_LEN_HI  = 4'd8;
  localparam logic [3:0] HPOS_CSUM    = 4'd9;

  // Result kinds
  localparam logic [2:0] KIND_HDR_OK   = 3'd0;
  localparam logic [2:0] KIND_HDR_BAD  = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD  = 3'd2;
  localparam logic [2:0] KIND_PKT_GOOD = 3'd3;
  localparam logic [2:0] KIND_DATA_BAD = 3'd4;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_DCHECK  = 4'b1000
  } pdc_phase_t;

  // One result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] target_address;
    logic [15:0] source_address;
    logic [15:0] sequence_index;
    logic [7:0]  function_code;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } pdc_result_t;

  // Write side of the result queue
  typedef struct packed {
    logic        valid;
    pdc_result_t data;
  } pdc_push_t;

endpackage

>>> sv/pdc_front.sv
module pdc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  input  logic                queue_full,
  output pdc_pkg::pdc_push_t  push
);
  import pdc_pkg::*;

  pdc_phase_t  phase_r, phase_nxt;
  logic [31:0] window_r, window_nxt;
  logic [3:0]  hdr_pos_r, hdr_pos_nxt;
  logic [15:0] tgt_r, tgt_nxt;
  logic [15:0] src_r, src_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  hdr_sum_r, hdr_sum_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [7:0]  pay_sum_r, pay_sum_nxt;

  logic        accept;
  logic [31:0] win_shift;
  logic [15:0] rem_dec;
  logic        emit;
  logic [2:0]  kind;
  logic [7:0]  dbyte;

  // Take a byte whenever the queue has room
  assign in_ready  = ~queue_full;
  assign accept    = in_valid & ~queue_full;
  assign win_shift = {window_r[23:0], in_rx_byte};
  assign rem_dec   = (remain_r != 16'd0) ? remain_r - 16'd1 : remain_r;

  // Byte classification and parser state update
  always_comb begin
    phase_nxt   = phase_r;
    window_nxt  = window_r;
    hdr_pos_nxt = hdr_pos_r;
    tgt_nxt     = tgt_r;
    src_nxt     = src_r;
    seq_nxt     = seq_r;
    func_nxt    = func_r;
    len_nxt     = len_r;
    hdr_sum_nxt = hdr_sum_r;
    remain_nxt  = remain_r;
    pay_sum_nxt = pay_sum_r;
    emit        = 1'b0;
    kind        = KIND_HDR_OK;
    dbyte       = 8'h00;
    if (accept) begin
      unique case (phase_r)
        PH_HUNT: begin
          window_nxt = win_shift;
          if (win_shift == SYNC_PATTERN) begin
            phase_nxt   = PH_HEADER;
            hdr_pos_nxt = HPOS_TGT_LO;
            hdr_sum_nxt = SYNC_SUM;
          end
        end
        PH_HEADER: begin
          if (hdr_pos_r < HPOS_CSUM) begin
            hdr_sum_nxt = hdr_sum_r + in_rx_byte;
            hdr_pos_nxt = hdr_pos_r + 4'd1;
            case (hdr_pos_r)
              HPOS_TGT_LO: tgt_nxt  = {8'h00, in_rx_byte};
              HPOS_TGT_HI: tgt_nxt  = {in_rx_byte, tgt_r[7:0]};
              HPOS_SRC_LO: src_nxt  = {8'h00, in_rx_byte};
              HPOS_SRC_HI: src_nxt  = {in_rx_byte, src_r[7:0]};
              HPOS_SEQ_LO: seq_nxt  = {8'h00, in_rx_byte};
              HPOS_SEQ_HI: seq_nxt  = {in_rx_byte, seq_r[7:0]};
              HPOS_FUNC:   func_nxt = in_rx_byte;
              HPOS_LEN_LO: len_nxt  = {8'h00, in_rx_byte};
              default:     len_nxt  = {in_rx_byte, len_r[7:0]};
            endcase
          end else begin
            // checksum byte: anything at or past the last position
            hdr_pos_nxt = HPOS_TGT_LO;
            emit        = 1'b1;
            if (in_rx_byte != hdr_sum_r) begin
              kind       = KIND_HDR_BAD;
              phase_nxt  = PH_HUNT;
              window_nxt = 32'd0;
            end else begin
              kind        = KIND_HDR_OK;
              remain_nxt  = len_r;
              pay_sum_nxt = 8'h00;
              phase_nxt   = (len_r != 16'd0) ? PH_PAYLOAD : PH_DCHECK;
            end
          end
        end
        PH_PAYLOAD: begin
          pay_sum_nxt = pay_sum_r + in_rx_byte;
          remain_nxt  = rem_dec;
          if (rem_dec == 16'd0) begin
            phase_nxt = PH_DCHECK;
          end
          emit  = 1'b1;
          kind  = KIND_PAYLOAD;
          dbyte = in_rx_byte;
        end
        PH_DCHECK: begin
          phase_nxt   = PH_HUNT;
          window_nxt  = 32'd0;
          hdr_pos_nxt = HPOS_TGT_LO;
          emit        = 1'b1;
          kind        = (in_rx_byte == pay_sum_r) ? KIND_PKT_GOOD : KIND_DATA_BAD;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  // Result record carries the header fields as currently held
  always_comb begin
    push.valid               = emit;
    push.data.kind           = kind;
    push.data.target_address = tgt_r;
    push.data.source_address = src_r;
    push.data.sequence_index = seq_r;
    push.data.function_code  = func_r;
    push.data.payload_length = len_r;
    push.data.data_byte      = dbyte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      window_r  <= 32'd0;
      hdr_pos_r <= 4'd0;
      tgt_r     <= 16'd0;
      src_r     <= 16'd0;
      seq_r     <= 16'd0;
      func_r    <= 8'd0;
      len_r     <= 16'd0;
      hdr_sum_r <= 8'd0;
      remain_r  <= 16'd0;
      pay_sum_r <= 8'd0;
    end else begin
      phase_r   <= phase_nxt;
      window_r  <= window_nxt;
      hdr_pos_r <= hdr_pos_nxt;
      tgt_r     <= tgt_nxt;
      src_r     <= src_nxt;
      seq_r     <= seq_nxt;
      func_r    <= func_nxt;
      len_r     <= len_nxt;
      hdr_sum_r <= hdr_sum_nxt;
      remain_r  <= remain_nxt;
      pay_sum_r <= pay_sum_nxt;
    end
  end

endmodule

>>> sv/pdc_queue.sv
module pdc_queue #(
  parameter int DEPTH = pdc_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pdc_pkg::pdc_push_t   push,
  input  logic                 pop,
  output logic                 full,
  output logic                 empty,
  output pdc_pkg::pdc_result_t head
);
  import pdc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pdc_result_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push.valid & ~full;
  assign do_pop  = pop & ~empty;

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.data;
    end
  end

endmodule

>>> sv/pdc_back.sv
module pdc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pdc_pkg::pdc_result_t head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_kind,
  output logic [15:0]          out_target_address,
  output logic [15:0]          out_source_address,
  output logic [15:0]          out_sequence_index,
  output logic [7:0]           out_function_code,
  output logic [15:0]          out_payload_length,
  output logic [7:0]           out_data_byte
);
  import pdc_pkg::*;

  logic        valid_r, valid_nxt;
  pdc_result_t res_r, res_nxt;

  // Refill the output register when it is empty or being taken
  assign pop = ~empty & (~valid_r | out_ready);

  always_comb begin
    valid_nxt = pop | (valid_r & ~out_ready);
    res_nxt   = pop ? head : res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid          = valid_r;
  assign out_kind           = res_r.kind;
  assign out_target_address = res_r.target_address;
  assign out_source_address = res_r.source_address;
  assign out_sequence_index = res_r.sequence_index;
  assign out_function_code  = res_r.function_code;
  assign out_payload_length = res_r.payload_length;
  assign out_data_byte      = res_r.data_byte;

endmodule

>>> sv/packet_deframer_checksum.sv
// Byte-stream deframer: hunts for the sync word EF 02 AA AA, parses a ten-byte
// little-endian header (target, source, sequence, function, length, checksum),
// then forwards the payload and checks its closing 8-bit sum. One result item
// at most per input byte: header ok/bad, payload byte, packet good/bad. The
// parser takes one byte every cycle while the result queue has room; a result
// reaches out_valid through a QUEUE_DEPTH-entry result queue and an output
// register. in_ready drops only while that queue is full, so
// the input sustains one byte per cycle as long as out_ready stays high.
module packet_deframer_checksum #(
  parameter int QUEUE_DEPTH = pdc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [15:0] out_target_address,
  output logic [15:0] out_source_address,
  output logic [15:0] out_sequence_index,
  output logic [7:0]  out_function_code,
  output logic [15:0] out_payload_length,
  output logic [7:0]  out_data_byte
);
  import pdc_pkg::*;

  pdc_push_t   push;
  pdc_result_t q_head;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;

  // Parser: accepts and classifies bytes
  pdc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .queue_full (q_full),
    .push       (push)
  );

  // Result queue between parser and output stage
  pdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  // Output register
  pdc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (q_head),
    .empty              (q_empty),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_target_address (out_target_address),
    .out_source_address (out_source_address),
    .out_sequence_index (out_sequence_index),
    .out_function_code  (out_function_code),
    .out_payload_length (out_payload_length),
    .out_data_byte      (out_data_byte)
  );

  // A result is only produced for an accepted byte
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (in_valid && in_ready))
    else $error("result pushed without an accepted byte");

  // Never push into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !q_full)
    else $error("result pushed into full queue");

  // Only payload results carry a data byte
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_PAYLOAD) |-> (out_data_byte == 8'h00))
    else $error("nonzero data byte on non-payload result");

  // Result kind stays within the defined codes
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind <= KIND_DATA_BAD))
    else $error("undefined result kind");

endmodule
